### sv/ucc_pkg.sv
// Shared types, case-mapping tables and match functions for the case converter.
package ucc_pkg;

   localparam int CP_W = 21;

   typedef logic [CP_W-1:0] cp_type;

   typedef enum logic [2:0] {
      RULE_NONE,
      RULE_SHIFT32,
      RULE_SHIFT80,
      RULE_EVEN,
      RULE_ODD
   } rule_type;

   typedef struct packed {
      cp_type lo;
      cp_type hi;
   } range_type;

   typedef struct packed {
      cp_type cap_cp;
      cp_type low_cp;
      logic   to_lower;
      logic   to_upper;
   } single_type;

   typedef struct packed {
      logic   hit;
      cp_type partner;
   } match_type;

   // stage 1 -> stage 2
   typedef struct packed {
      logic     mode;
      cp_type   cp;
      rule_type rule;
   } s1_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic     mode;
      cp_type   cp;
      rule_type rule;
      logic     single_hit;
      cp_type   partner;
   } s2_type;

   localparam cp_type BLOCK_SHIFT  = 21'd32;
   localparam cp_type CYR_SHIFT    = 21'd80;
   localparam cp_type CYR_CAP_LO   = 21'h000400;
   localparam cp_type CYR_CAP_HI   = 21'h00040f;
   localparam cp_type CYR_LOW_LO   = 21'h000450;
   localparam cp_type CYR_LOW_HI   = 21'h00045f;

   localparam int N_SHIFT32 = 6;
   localparam int N_EVEN    = 13;
   localparam int N_ODD     = 6;
   localparam int N_SINGLE  = 43;

   // block ranges on the capital side
   localparam range_type SHIFT32_TAB [N_SHIFT32] = '{
      '{21'h0041, 21'h005a}, '{21'h00c0, 21'h00d6}, '{21'h00d8, 21'h00de},
      '{21'h0391, 21'h03a1}, '{21'h03a3, 21'h03ab}, '{21'h0410, 21'h042f}
   };

   localparam range_type EVEN_TAB [N_EVEN] = '{
      '{21'h0100, 21'h012f}, '{21'h0132, 21'h0137}, '{21'h014a, 21'h0177},
      '{21'h0182, 21'h0185}, '{21'h01a0, 21'h01a5}, '{21'h01de, 21'h01ef},
      '{21'h01f8, 21'h021f}, '{21'h0222, 21'h0233}, '{21'h0246, 21'h024f},
      '{21'h03d8, 21'h03ef}, '{21'h0460, 21'h0481}, '{21'h048a, 21'h04bf},
      '{21'h04d0, 21'h04ff}
   };

   localparam range_type ODD_TAB [N_ODD] = '{
      '{21'h0139, 21'h0148}, '{21'h0179, 21'h017e}, '{21'h01af, 21'h01b0},
      '{21'h01b3, 21'h01b6}, '{21'h01cd, 21'h01dc}, '{21'h04c1, 21'h04ce}
   };

   localparam single_type SINGLE_TAB [N_SINGLE] = '{
      '{21'h0178, 21'h00ff, 1'b1, 1'b1}, '{21'h0243, 21'h0180, 1'b1, 1'b1},
      '{21'h018e, 21'h01dd, 1'b1, 1'b1}, '{21'h023d, 21'h019a, 1'b1, 1'b1},
      '{21'h0220, 21'h019e, 1'b1, 1'b1}, '{21'h01b7, 21'h0292, 1'b1, 1'b1},
      '{21'h01c4, 21'h01c6, 1'b1, 1'b1}, '{21'h01c7, 21'h01c9, 1'b1, 1'b1},
      '{21'h01ca, 21'h01cc, 1'b1, 1'b1}, '{21'h01f1, 21'h01f3, 1'b1, 1'b1},
      '{21'h01f7, 21'h01bf, 1'b1, 1'b1}, '{21'h0187, 21'h0188, 1'b1, 1'b1},
      '{21'h018b, 21'h018c, 1'b1, 1'b1}, '{21'h0191, 21'h0192, 1'b1, 1'b1},
      '{21'h0198, 21'h0199, 1'b1, 1'b1}, '{21'h01a7, 21'h01a8, 1'b1, 1'b1},
      '{21'h01ac, 21'h01ad, 1'b1, 1'b1}, '{21'h01b8, 21'h01b9, 1'b1, 1'b1},
      '{21'h01bc, 21'h01bd, 1'b1, 1'b1}, '{21'h01f4, 21'h01f5, 1'b1, 1'b1},
      '{21'h023b, 21'h023c, 1'b1, 1'b1}, '{21'h0241, 21'h0242, 1'b1, 1'b1},
      '{21'h03fd, 21'h037b, 1'b1, 1'b1}, '{21'h03fe, 21'h037c, 1'b1, 1'b1},
      '{21'h03ff, 21'h037d, 1'b1, 1'b1}, '{21'h037f, 21'h03f3, 1'b1, 1'b1},
      '{21'h0386, 21'h03ac, 1'b1, 1'b1}, '{21'h0388, 21'h03ad, 1'b1, 1'b1},
      '{21'h0389, 21'h03ae, 1'b1, 1'b1}, '{21'h038a, 21'h03af, 1'b1, 1'b1},
      '{21'h038c, 21'h03cc, 1'b1, 1'b1}, '{21'h038e, 21'h03cd, 1'b1, 1'b1},
      '{21'h038f, 21'h03ce, 1'b1, 1'b1}, '{21'h0370, 21'h0371, 1'b1, 1'b1},
      '{21'h0372, 21'h0373, 1'b1, 1'b1}, '{21'h0376, 21'h0377, 1'b1, 1'b1},
      '{21'h03cf, 21'h03d7, 1'b1, 1'b1}, '{21'h03f9, 21'h03f2, 1'b1, 1'b1},
      '{21'h03f7, 21'h03f8, 1'b1, 1'b1}, '{21'h03fa, 21'h03fb, 1'b1, 1'b1},
      '{21'h04c0, 21'h04cf, 1'b1, 1'b1},
      '{21'h03f4, 21'h03b8, 1'b1, 1'b0}, '{21'h0398, 21'h03d1, 1'b0, 1'b1}
   };

   // upper-casing looks for the small side, which sits 32 above the capital
   function automatic logic in_shift32(input cp_type cp, input logic up);
      logic   hit;
      cp_type off;
      hit = 1'b0;
      off = up ? BLOCK_SHIFT : '0;
      for (int i = 0; i < N_SHIFT32; i++) begin
         if (cp >= SHIFT32_TAB[i].lo + off && cp <= SHIFT32_TAB[i].hi + off) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic in_shift80(input cp_type cp, input logic up);
      logic hit;
      if (up) begin
         hit = (cp >= CYR_LOW_LO) && (cp <= CYR_LOW_HI);
      end else begin
         hit = (cp >= CYR_CAP_LO) && (cp <= CYR_CAP_HI);
      end
      return hit;
   endfunction

   function automatic logic in_even(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < N_EVEN; i++) begin
         if (cp >= EVEN_TAB[i].lo && cp <= EVEN_TAB[i].hi) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic in_odd(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < N_ODD; i++) begin
         if (cp >= ODD_TAB[i].lo && cp <= ODD_TAB[i].hi) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // lowest table entry wins, hence the downward sweep
   function automatic match_type find_single(input cp_type cp, input logic up);
      match_type m;
      m = '0;
      for (int i = N_SINGLE - 1; i >= 0; i--) begin
         if (up) begin
            if (SINGLE_TAB[i].to_upper && cp == SINGLE_TAB[i].low_cp) begin
               m.hit     = 1'b1;
               m.partner = SINGLE_TAB[i].cap_cp;
            end
         end else begin
            if (SINGLE_TAB[i].to_lower && cp == SINGLE_TAB[i].cap_cp) begin
               m.hit     = 1'b1;
               m.partner = SINGLE_TAB[i].low_cp;
            end
         end
      end
      return m;
   endfunction

endpackage

### sv/ucc_classify.sv
// Stage 1: range classification of the incoming code point.
module ucc_classify (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  logic            up_mode,
   input  ucc_pkg::cp_type up_cp,
   output logic            dn_valid,
   input  logic            dn_ready,
   output ucc_pkg::s1_type dn_data
);
   import ucc_pkg::*;

   logic     valid_ff, valid_in;
   s1_type   data_ff, data_in;
   rule_type rule;

   always_comb begin
      if (in_shift32(up_cp, up_mode)) begin
         rule = RULE_SHIFT32;
      end else if (in_shift80(up_cp, up_mode)) begin
         rule = RULE_SHIFT80;
      end else if (in_even(up_cp)) begin
         rule = RULE_EVEN;
      end else if (in_odd(up_cp)) begin
         rule = RULE_ODD;
      end else begin
         rule = RULE_NONE;
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      data_in      = data_ff;
      if (up_ready && up_valid) begin
         data_in.mode = up_mode;
         data_in.cp   = up_cp;
         data_in.rule = rule;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### sv/ucc_lookup.sv
// Stage 2: single-point exception lookup, used only where no range rule hit.
module ucc_lookup (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  ucc_pkg::s1_type up_data,
   output logic            dn_valid,
   input  logic            dn_ready,
   output ucc_pkg::s2_type dn_data
);
   import ucc_pkg::*;

   logic      valid_ff, valid_in;
   s2_type    data_ff, data_in;
   match_type m;

   assign m        = find_single(up_data.cp, up_data.mode);
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      data_in = data_ff;
      if (up_ready && up_valid) begin
         data_in.mode       = up_data.mode;
         data_in.cp         = up_data.cp;
         data_in.rule       = up_data.rule;
         data_in.single_hit = m.hit && (up_data.rule == RULE_NONE);
         data_in.partner    = m.partner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### sv/ucc_apply.sv
// Stage 3: applies the chosen rule and holds the result beat.
module ucc_apply (
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  ucc_pkg::s2_type up_data,
   output logic            dn_valid,
   input  logic            dn_ready,
   output ucc_pkg::cp_type dn_cp
);
   import ucc_pkg::*;

   logic   valid_ff, valid_in;
   cp_type cp_ff, cp_in;
   cp_type mapped;
   cp_type one;

   assign one = cp_type'(1);

   always_comb begin
      case (up_data.rule)
         RULE_SHIFT32: begin
            mapped = up_data.mode ? up_data.cp - BLOCK_SHIFT : up_data.cp + BLOCK_SHIFT;
         end
         RULE_SHIFT80: begin
            mapped = up_data.mode ? up_data.cp - CYR_SHIFT : up_data.cp + CYR_SHIFT;
         end
         RULE_EVEN: begin
            mapped = up_data.mode ? up_data.cp & ~one : up_data.cp | one;
         end
         RULE_ODD: begin
            mapped = up_data.mode ? (up_data.cp - one) | one
                                  : (up_data.cp + one) & ~one;
         end
         default: begin
            mapped = up_data.single_hit ? up_data.partner : up_data.cp;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign cp_in    = (up_ready && up_valid) ? mapped : cp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff <= cp_in;
   end

   assign dn_valid = valid_ff;
   assign dn_cp    = cp_ff;

endmodule

### sv/unicode_case_converter_core.sv
// Top level of the case converter: three-stage pipeline from code point to mapped point.
//
//  channel  direction  tdata                       tuser
//  req_     in         [20:0] code_point           [0] mode (1 = to upper)
//  rsp_     out        [20:0] mapped_point         -
//
// One beat per cycle while rsp_tready is high; each beat is registered in classify, exception lookup and apply in turn.
// Each stage holds its own valid bit; reset clears those only.
// rsp_tready low holds every full stage; req_tready drops once stage one is full
// and the stall reaches it. No beat is lost or repeated.
module unicode_case_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [20:0] mapped_point, [23:21] zero
);
   import ucc_pkg::*;

   logic   s1_valid, s1_ready;
   s1_type s1_data;
   logic   s2_valid, s2_ready;
   s2_type s2_data;
   cp_type out_cp;

   ucc_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_mode  (req_tuser),
      .up_cp    (req_tdata[CP_W-1:0]),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   ucc_lookup u_lookup (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   ucc_apply u_apply (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_cp    (out_cp)
   );

   assign rsp_tdata = {(24 - CP_W)'(0), out_cp};

   // an accepted beat always lands in stage one
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid)
      else $error("accepted beat missing from stage one");

   // back-pressure at the input only when stage one is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid)
      else $error("input stalled with stage one empty");

   // exceptions never override a range rule
   a_single_prio: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && s2_data.single_hit) |-> (s2_data.rule == RULE_NONE))
      else $error("exception hit alongside a range rule");

endmodule

### dv/tb.sv
// Self-checking stream testbench for the Unicode case converter core.
`timescale 1ns / 100ps

module tb;

   localparam int QUIET_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1650;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic             mode;
      ucc_pkg::cp_type  cp;
      logic [6:0]       idle_pct;
      logic [6:0]       stall_pct;
   } req_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [20:0] code_point, [23:21] zero
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [20:0] mapped_point, [23:21] zero

   req_item_type    pending_q[$];
   ucc_pkg::cp_type mapped_q[$];
   req_item_type    drv_item;
   ucc_pkg::cp_type want_cp;
   logic [6:0]      stall_pct = '0;
   logic            req_beat_done = 1'b0;
   int              quiet_cycles = 0;
   int              fault_count = 0;

   unicode_case_converter_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic logic in_span(input ucc_pkg::cp_type cp, input int lo, input int hi);
      return (cp >= lo) && (cp <= hi);
   endfunction

   function automatic logic block32_cap(input ucc_pkg::cp_type cp);
      return in_span(cp, 'h0041, 'h005a) || in_span(cp, 'h00c0, 'h00d6) ||
             in_span(cp, 'h00d8, 'h00de) || in_span(cp, 'h0391, 'h03a1) ||
             in_span(cp, 'h03a3, 'h03ab) || in_span(cp, 'h0410, 'h042f);
   endfunction

   function automatic logic even_pair(input ucc_pkg::cp_type cp);
      return in_span(cp, 'h0100, 'h012f) || in_span(cp, 'h0132, 'h0137) ||
             in_span(cp, 'h014a, 'h0177) || in_span(cp, 'h0182, 'h0185) ||
             in_span(cp, 'h01a0, 'h01a5) || in_span(cp, 'h01de, 'h01ef) ||
             in_span(cp, 'h01f8, 'h021f) || in_span(cp, 'h0222, 'h0233) ||
             in_span(cp, 'h0246, 'h024f) || in_span(cp, 'h03d8, 'h03ef) ||
             in_span(cp, 'h0460, 'h0481) || in_span(cp, 'h048a, 'h04bf) ||
             in_span(cp, 'h04d0, 'h04ff);
   endfunction

   function automatic logic odd_pair(input ucc_pkg::cp_type cp);
      return in_span(cp, 'h0139, 'h0148) || in_span(cp, 'h0179, 'h017e) ||
             in_span(cp, 'h01af, 'h01b0) || in_span(cp, 'h01b3, 'h01b6) ||
             in_span(cp, 'h01cd, 'h01dc) || in_span(cp, 'h04c1, 'h04ce);
   endfunction

   // expected case partner; first matching rule wins, unmatched points pass through
   function automatic ucc_pkg::cp_type case_partner(input logic up, input ucc_pkg::cp_type cp);
      if (!up) begin
         if (block32_cap(cp)) return cp + 21'd32;
         if (in_span(cp, 'h0400, 'h040f)) return cp + 21'd80;
         if (even_pair(cp)) return cp | 21'd1;
         if (odd_pair(cp)) return (cp + 21'd1) & ~21'd1;
         case (cp)
            21'h0178: return 21'h00ff;   21'h0243: return 21'h0180;
            21'h018e: return 21'h01dd;   21'h023d: return 21'h019a;
            21'h0220: return 21'h019e;   21'h01b7: return 21'h0292;
            21'h01c4: return 21'h01c6;   21'h01c7: return 21'h01c9;
            21'h01ca: return 21'h01cc;   21'h01f1: return 21'h01f3;
            21'h01f7: return 21'h01bf;   21'h0187: return 21'h0188;
            21'h018b: return 21'h018c;   21'h0191: return 21'h0192;
            21'h0198: return 21'h0199;   21'h01a7: return 21'h01a8;
            21'h01ac: return 21'h01ad;   21'h01b8: return 21'h01b9;
            21'h01bc: return 21'h01bd;   21'h01f4: return 21'h01f5;
            21'h023b: return 21'h023c;   21'h0241: return 21'h0242;
            21'h03fd: return 21'h037b;   21'h03fe: return 21'h037c;
            21'h03ff: return 21'h037d;   21'h037f: return 21'h03f3;
            21'h0386: return 21'h03ac;   21'h0388: return 21'h03ad;
            21'h0389: return 21'h03ae;   21'h038a: return 21'h03af;
            21'h038c: return 21'h03cc;   21'h038e: return 21'h03cd;
            21'h038f: return 21'h03ce;   21'h0370: return 21'h0371;
            21'h0372: return 21'h0373;   21'h0376: return 21'h0377;
            21'h03cf: return 21'h03d7;   21'h03f9: return 21'h03f2;
            21'h03f7: return 21'h03f8;   21'h03fa: return 21'h03fb;
            21'h04c0: return 21'h04cf;
            21'h03f4: return 21'h03b8;   // lower only
            default: return cp;
         endcase
      end else begin
         if (block32_cap(cp - 21'd32) && cp >= 21'd32) return cp - 21'd32;
         if (in_span(cp, 'h0450, 'h045f)) return cp - 21'd80;
         if (even_pair(cp)) return cp & ~21'd1;
         if (odd_pair(cp)) return (cp - 21'd1) | 21'd1;
         case (cp)
            21'h00ff: return 21'h0178;   21'h0180: return 21'h0243;
            21'h01dd: return 21'h018e;   21'h019a: return 21'h023d;
            21'h019e: return 21'h0220;   21'h0292: return 21'h01b7;
            21'h01c6: return 21'h01c4;   21'h01c9: return 21'h01c7;
            21'h01cc: return 21'h01ca;   21'h01f3: return 21'h01f1;
            21'h01bf: return 21'h01f7;   21'h0188: return 21'h0187;
            21'h018c: return 21'h018b;   21'h0192: return 21'h0191;
            21'h0199: return 21'h0198;   21'h01a8: return 21'h01a7;
            21'h01ad: return 21'h01ac;   21'h01b9: return 21'h01b8;
            21'h01bd: return 21'h01bc;   21'h01f5: return 21'h01f4;
            21'h023c: return 21'h023b;   21'h0242: return 21'h0241;
            21'h037b: return 21'h03fd;   21'h037c: return 21'h03fe;
            21'h037d: return 21'h03ff;   21'h03f3: return 21'h037f;
            21'h03ac: return 21'h0386;   21'h03ad: return 21'h0388;
            21'h03ae: return 21'h0389;   21'h03af: return 21'h038a;
            21'h03cc: return 21'h038c;   21'h03cd: return 21'h038e;
            21'h03ce: return 21'h038f;   21'h0371: return 21'h0370;
            21'h0373: return 21'h0372;   21'h0377: return 21'h0376;
            21'h03d7: return 21'h03cf;   21'h03f2: return 21'h03f9;
            21'h03f8: return 21'h03f7;   21'h03fb: return 21'h03fa;
            21'h04cf: return 21'h04c0;
            21'h03d1: return 21'h0398;   // upper only
            default: return cp;
         endcase
      end
   endfunction

   // mostly the mapped scripts, some of everything else
   function automatic ucc_pkg::cp_type pick_code_point();
      int r;
      r = $urandom_range(99);
      if (r < 72) return ucc_pkg::cp_type'($urandom_range(21'h0600, 0));
      if (r < 80) return ucc_pkg::cp_type'($urandom_range(21'h1fffff, 21'h10fff0));
      if (r < 92) return ucc_pkg::cp_type'($urandom & 21'h1fffff);
      return ucc_pkg::cp_type'($urandom_range(21'h00e010, 21'h00d7f0));
   endfunction

   task automatic queue_char(input logic mode, input int cp, input int idle, input int stall);
      req_item_type it;
      it.mode      = mode;
      it.cp        = ucc_pkg::cp_type'(cp);
      it.idle_pct  = 7'(idle);
      it.stall_pct = 7'(stall);
      pending_q.push_back(it);
   endtask

   // driver: new beat only once the previous one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || req_beat_done) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
               drv_item = pending_q.pop_front();
               stall_pct = drv_item.stall_pct;
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, drv_item.cp};
               req_tuser  <= drv_item.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         req_beat_done = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_beat_done = req_tvalid && req_tready;
         if (req_beat_done) begin
            mapped_q.push_back(case_partner(req_tuser, req_tdata[20:0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (mapped_q.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $display("unexpected result beat: mapped_point %h", rsp_tdata);
               end
            end else begin
               want_cp = mapped_q.pop_front();
               if (rsp_tdata !== {3'b000, want_cp}) begin
                  fault_count++;
                  if (fault_count <= MAX_REPORTS) begin
                     $display("mapped_point mismatch: expected %h, got %h",
                              {3'b000, want_cp}, rsp_tdata);
                  end
               end
            end
         end
         if (req_beat_done || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      // field extremes and the scalar-range edge
      queue_char(1'b0, 'h000000, 0, 0);
      queue_char(1'b1, 'h1fffff, 0, 0);
      queue_char(1'b0, 'h10ffff, 0, 0);
      queue_char(1'b1, 'h0d800,  0, 0);   // surrogate
      // block shifts
      queue_char(1'b0, 'h0041, 0, 0);
      queue_char(1'b1, 'h007a, 0, 0);
      queue_char(1'b0, 'h0400, 0, 0);
      queue_char(1'b1, 'h045f, 0, 0);
      // paired ranges
      queue_char(1'b0, 'h0100, 0, 0);
      queue_char(1'b1, 'h0101, 0, 0);
      queue_char(1'b0, 'h0139, 0, 0);
      queue_char(1'b1, 'h013a, 0, 0);
      // palochka and the odd-capital Cyrillic pairs
      queue_char(1'b0, 'h04c0, 0, 0);
      queue_char(1'b1, 'h04cf, 0, 0);
      queue_char(1'b0, 'h04c1, 0, 0);
      queue_char(1'b1, 'h04ce, 0, 0);
      // one-way exceptions, both directions
      queue_char(1'b0, 'h03f4, 0, 0);
      queue_char(1'b1, 'h03f4, 0, 0);
      queue_char(1'b1, 'h03d1, 0, 0);
      queue_char(1'b0, 'h03d1, 0, 0);
      queue_char(1'b1, 'h03b8, 0, 0);
      queue_char(1'b0, 'h0398, 0, 0);
      // title case passes through, then one exception is lowered
      queue_char(1'b0, 'h01c5, 0, 0);
      queue_char(1'b1, 'h01c5, 0, 0);
      queue_char(1'b0, 'h0178, 0, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case (i * 4 / RANDOM_ITEMS)
            0: queue_char(1'($urandom_range(1)), pick_code_point(), 0, 0);
            1: queue_char(1'($urandom_range(1)), pick_code_point(), 64, 0);
            2: queue_char(1'($urandom_range(1)), pick_code_point(), 0, 64);
            default: queue_char(1'($urandom_range(1)), pick_code_point(), 20, 20);
         endcase
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && mapped_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
